// ===== sv/dqc_pkg.sv =====
// ----------------------------------------------------------------------------
// dqc_pkg
// Types and constants shared by the dual quadrature counter core.
// ----------------------------------------------------------------------------
package dqc_pkg;

  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgLeftInvert  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgRightInvert = 1'd1;

  localparam logic LeftInvertRst  = 1'b0;
  localparam logic RightInvertRst = 1'b1;

  typedef struct packed {
    logic left_a;
    logic left_b;
    logic right_a;
    logic right_b;
    logic clear_counts;
    logic take_left_delta;
    logic take_right_delta;
  } dqc_in_t;

  typedef struct packed {
    logic signed [31:0] left_total;
    logic signed [31:0] right_total;
    logic signed [31:0] left_change;
    logic signed [31:0] right_change;
  } dqc_out_t;

endpackage

// ===== sv/dual_quadrature_counter_core.sv =====
// ----------------------------------------------------------------------------
// dual_quadrature_counter_core
// Two-wheel quadrature counter at 2x resolution with delta marks.
// ----------------------------------------------------------------------------
// One sample beat is taken per clock. The position, mark and previous-B
// registers are updated at the input handshake, and the result beat is
// loaded into an output register the same cycle, so a new beat can enter
// every cycle while the output register is empty or being drained. Only a
// stalled, full output register holds off input. The longest path per
// wheel is one increment followed by the delta subtract. Counts are
// COUNT_BITS wide, wrap, and are sign-extended or cut to the 32-bit
// result fields.
module dual_quadrature_counter_core #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,

  input  logic                      cfg_we_i,
  input  logic [dqc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic                      cfg_wdata_i,

  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  dqc_pkg::dqc_in_t          in_data_i,

  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output dqc_pkg::dqc_out_t         out_data_o
);
  import dqc_pkg::*;

  typedef logic signed [COUNT_BITS-1:0] cnt_t;

  logic     left_inv_q, right_inv_q;
  logic     prev_lb_q, prev_rb_q;
  cnt_t     lpos_q, rpos_q, lmark_q, rmark_q;
  cnt_t     lpos_d, rpos_d, lmark_d, rmark_d;
  cnt_t     lchg, rchg;
  logic     out_valid_q;
  dqc_out_t out_data_q, out_data_d;
  logic     in_acc;

  function automatic cnt_t wheel_step(cnt_t pos, logic a, logic b, logic pb,
                                      logic inv);
    cnt_t r;
    r = pos;
    if (b != pb) begin
      if ((a != b) ^ inv) begin
        r = pos + cnt_t'(1);
      end else begin
        r = pos - cnt_t'(1);
      end
    end
    return r;
  endfunction

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_data_i.clear_counts) begin
      lpos_d  = '0;
      rpos_d  = '0;
      lmark_d = '0;
      rmark_d = '0;
    end else begin
      lpos_d  = wheel_step(lpos_q, in_data_i.left_a, in_data_i.left_b,
                           prev_lb_q, left_inv_q);
      rpos_d  = wheel_step(rpos_q, in_data_i.right_a, in_data_i.right_b,
                           prev_rb_q, right_inv_q);
      lmark_d = lmark_q;
      rmark_d = rmark_q;
    end
    lchg = '0;
    rchg = '0;
    if (in_data_i.take_left_delta) begin
      lchg    = lpos_d - lmark_d;
      lmark_d = lpos_d;
    end
    if (in_data_i.take_right_delta) begin
      rchg    = rpos_d - rmark_d;
      rmark_d = rpos_d;
    end
    out_data_d.left_total   = 32'(lpos_d);
    out_data_d.right_total  = 32'(rpos_d);
    out_data_d.left_change  = 32'(lchg);
    out_data_d.right_change = 32'(rchg);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_inv_q  <= LeftInvertRst;
      right_inv_q <= RightInvertRst;
      prev_lb_q   <= 1'b0;
      prev_rb_q   <= 1'b0;
      lpos_q      <= '0;
      rpos_q      <= '0;
      lmark_q     <= '0;
      rmark_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgLeftInvert) begin
          left_inv_q <= cfg_wdata_i;
        end
        if (cfg_idx_i == CfgRightInvert) begin
          right_inv_q <= cfg_wdata_i;
        end
      end
      if (in_acc) begin
        prev_lb_q   <= in_data_i.left_b;
        prev_rb_q   <= in_data_i.right_b;
        lpos_q      <= lpos_d;
        rpos_q      <= rpos_d;
        lmark_q     <= lmark_d;
        rmark_q     <= rmark_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // clear zeroes both totals of the resulting beat
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.clear_counts |=>
      out_valid_o && out_data_o.left_total == 0 && out_data_o.right_total == 0)
    else $error("clear did not zero totals");

  // no take means zero change fields
  a_no_take_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_data_i.take_left_delta && !in_data_i.take_right_delta |=>
      out_data_o.left_change == 0 && out_data_o.right_change == 0)
    else $error("change reported without take");

  // without a B edge or clear the left position holds
  a_left_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_data_i.clear_counts && in_data_i.left_b == prev_lb_q |=>
      lpos_q == $past(lpos_q))
    else $error("left position moved without edge");

  // a taken delta leaves the mark at the position
  a_mark_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.take_right_delta |=> rmark_q == rpos_q)
    else $error("right mark not moved on take");

endmodule
